// ===== hw/rtl/tei_pkg.sv =====
`default_nettype none

package tei_pkg;

	// field widths
	localparam int ORB_W      = 6;
	localparam int FLAT_W     = 24;
	localparam int MODE_W     = 3;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 4;
	localparam int TRI_W      = 12;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;
	localparam int STAGES     = 4;

	// symmetry modes; the two unused codes pack as no symmetry
	localparam logic [MODE_W-1:0] MODE_NONE           = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HERMITIAN      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DUMMY_EXCHANGE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FOUR_COMPLEX   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FOUR_NONHERM   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_EIGHTFOLD      = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SYMMETRY_MODE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORBITAL_COUNT = 4'd1;

	// per-stage load enables from the pipeline control
	typedef struct packed {
		logic [STAGES-1:0] en;
	} ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tei_cfg.sv =====
`default_nettype none

module tei_cfg
	import tei_pkg::*;
#(
	parameter int MAX_ORBITALS = 64,
	localparam int NW = ($clog2(MAX_ORBITALS + 1) > CNT_W) ? $clog2(MAX_ORBITALS + 1) : CNT_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CNT_W-1:0]     cfg_data,
	output logic [MODE_W-1:0]         mode,
	output logic [NW-1:0]             n
);

	logic [MODE_W-1:0] mode_q;
	logic [NW-1:0]     n_q;

	assign cfg_ready = 1'b1;
	assign mode      = mode_q;
	assign n         = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EIGHTFOLD;
			n_q    <= NW'(MAX_ORBITALS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SYMMETRY_MODE: begin
					mode_q <= cfg_data[MODE_W-1:0];
				end
				REG_ORBITAL_COUNT: begin
					// counts above the build limit saturate
					if (32'(cfg_data) > 32'(MAX_ORBITALS)) begin
						n_q <= NW'(MAX_ORBITALS);
					end else begin
						n_q <= NW'(cfg_data);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tei_ctrl.sv =====
`default_nettype none

module tei_ctrl
	import tei_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output logic      m_tvalid,
	input  wire logic m_tready,
	output ctrl_t     ctrl
);

	logic [STAGES-1:0] vld_q;
	logic [STAGES:0]   rdy;

	// a stage loads when empty or when the stage after it moves on
	always_comb begin
		rdy[STAGES] = m_tready;
		for (int k = STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign ctrl.en   = rdy[STAGES-1:0];
	assign s_tready  = rdy[0];
	assign m_tvalid  = vld_q[STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= (k == 0) ? s_tvalid : vld_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tei_datapath.sv =====
`default_nettype none

module tei_datapath
	import tei_pkg::*;
#(
	parameter int MAX_ORBITALS = 64,
	localparam int NW = ($clog2(MAX_ORBITALS + 1) > CNT_W) ? $clog2(MAX_ORBITALS + 1) : CNT_W
) (
	input  wire logic              clk,
	input  wire ctrl_t             ctrl,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [NW-1:0]     n,
	input  wire logic [ORB_W-1:0]  orb_a,
	input  wire logic [ORB_W-1:0]  orb_b,
	input  wire logic [ORB_W-1:0]  orb_i,
	input  wire logic [ORB_W-1:0]  orb_j,
	output logic [FLAT_W-1:0]      flat_index,
	output logic                   conjugate,
	output logic                   out_of_range
);

	localparam int PW  = ORB_W + NW;   // pair index x*n+y
	localparam int HW  = 2 * NW;       // h(n)
	localparam int OBW = PW + 1;       // second multiplier operand

	function automatic logic [TRI_W-1:0] tri_ord6(input logic [ORB_W-1:0] x,
		input logic [ORB_W-1:0] y);
		logic [ORB_W-1:0]   hi;
		logic [ORB_W-1:0]   lo;
		logic [2*ORB_W:0]   pr;
		hi = (x >= y) ? x : y;
		lo = (x >= y) ? y : x;
		pr = (2*ORB_W+1)'(hi) * ((2*ORB_W+1)'(hi) + (2*ORB_W+1)'(1));
		return pr[2*ORB_W:1] + TRI_W'(lo);
	endfunction

	// stage 1: range check, orbital strides, small triangles, h(n)
	logic              oor_c;
	logic [HW:0]       hp_c;

	logic [MODE_W-1:0] mode_s1;
	logic              oor_s1;
	logic [NW-1:0]     n_s1;
	logic [PW-1:0]     an_s1, bn_s1, in_s1;
	logic [ORB_W-1:0]  b_s1, i_s1, j_s1;
	logic [TRI_W-1:0]  u_s1, v_s1;
	logic              bj_s1, ai_s1;
	logic [HW-1:0]     hn_s1;

	assign oor_c = (NW'(orb_a) >= n) || (NW'(orb_b) >= n) ||
		(NW'(orb_i) >= n) || (NW'(orb_j) >= n);
	assign hp_c  = (HW+1)'(n) * ((HW+1)'(n) + (HW+1)'(1));

	always_ff @(posedge clk) begin
		if (ctrl.en[0]) begin
			mode_s1 <= mode;
			oor_s1  <= oor_c;
			n_s1    <= n;
			an_s1   <= PW'(orb_a) * PW'(n);
			bn_s1   <= PW'(orb_b) * PW'(n);
			in_s1   <= PW'(orb_i) * PW'(n);
			b_s1    <= orb_b;
			i_s1    <= orb_i;
			j_s1    <= orb_j;
			u_s1    <= tri_ord6(orb_b, orb_j);
			v_s1    <= tri_ord6(orb_a, orb_i);
			bj_s1   <= orb_b >= orb_j;
			ai_s1   <= orb_a >= orb_i;
			hn_s1   <= hp_c[HW:1];
		end
	end

	// stage 2: pair indices, ordering, dense partial product, half offset
	logic [PW-1:0]     p1_c, q1_c, p2_c, q2_c, x_c, y_c;
	logic [PW+NW-1:0]  m0_full_c;
	logic [2*HW:0]     hh_c;
	logic              none_c;

	logic              none_s2, oor_s2, ord_s2, bj_s2, ai_s2;
	logic [MODE_W-1:0] mode_s2;
	logic [NW-1:0]     n_s2;
	logic [FLAT_W-1:0] m0_s2, half_s2;
	logic [ORB_W-1:0]  i_s2, j_s2;
	logic [PW-1:0]     mx_s2, mn_s2;

	assign p1_c      = an_s1 + PW'(b_s1);
	assign q1_c      = in_s1 + PW'(j_s1);
	assign p2_c      = an_s1 + PW'(i_s1);
	assign q2_c      = bn_s1 + PW'(j_s1);
	assign m0_full_c = (PW+NW)'(p1_c) * (PW+NW)'(n_s1);
	assign hh_c      = (2*HW+1)'(hn_s1) * ((2*HW+1)'(hn_s1) + (2*HW+1)'(1));
	assign none_c    = !(mode_s1 inside {[MODE_HERMITIAN:MODE_EIGHTFOLD]});

	always_comb begin
		case (mode_s1)
			MODE_DUMMY_EXCHANGE: begin
				x_c = p2_c;
				y_c = q2_c;
			end
			MODE_FOUR_COMPLEX, MODE_FOUR_NONHERM, MODE_EIGHTFOLD: begin
				x_c = PW'(u_s1);
				y_c = PW'(v_s1);
			end
			default: begin
				x_c = p1_c;
				y_c = q1_c;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[1]) begin
			none_s2 <= none_c;
			mode_s2 <= mode_s1;
			oor_s2  <= oor_s1;
			n_s2    <= n_s1;
			m0_s2   <= FLAT_W'(m0_full_c);
			half_s2 <= FLAT_W'(hh_c >> 1);
			i_s2    <= i_s1;
			j_s2    <= j_s1;
			ord_s2  <= x_c >= y_c;
			mx_s2   <= (x_c >= y_c) ? x_c : y_c;
			mn_s2   <= (x_c >= y_c) ? y_c : x_c;
			bj_s2   <= bj_s1;
			ai_s2   <= ai_s1;
		end
	end

	// stage 3: shared multiplier, offset choice and conjugation
	logic [FLAT_W-1:0]     opa_c;
	logic [OBW-1:0]        opb_c;
	logic [FLAT_W+OBW-1:0] prod_full_c;
	logic                  addh_c, conj_c;

	logic [FLAT_W:0]       prod_s3;
	logic [FLAT_W-1:0]     addend_s3;
	logic                  none_s3, conj_s3, oor_s3;

	// dense mode: (p*n + i) * n, otherwise mx * (mx + 1)
	assign opa_c       = none_s2 ? (m0_s2 + FLAT_W'(i_s2)) : FLAT_W'(mx_s2);
	assign opb_c       = none_s2 ? OBW'(n_s2) : (OBW'(mx_s2) + OBW'(1));
	assign prod_full_c = (FLAT_W+OBW)'(opa_c) * (FLAT_W+OBW)'(opb_c);

	always_comb begin
		addh_c = 1'b0;
		conj_c = 1'b0;
		case (mode_s2)
			MODE_HERMITIAN: begin
				conj_c = !ord_s2;
			end
			MODE_FOUR_COMPLEX: begin
				addh_c = bj_s2 != ai_s2;
				conj_c = (bj_s2 == ai_s2) ? !bj_s2 : (bj_s2 == ord_s2);
			end
			MODE_FOUR_NONHERM: begin
				if (bj_s2 && ai_s2) begin
					addh_c = 1'b0;
				end else if (bj_s2) begin
					addh_c = ord_s2;
				end else if (ai_s2) begin
					addh_c = !ord_s2;
				end else begin
					addh_c = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.en[2]) begin
			prod_s3   <= prod_full_c[FLAT_W:0];
			addend_s3 <= (none_s2 ? FLAT_W'(j_s2) : FLAT_W'(mn_s2)) +
				(addh_c ? half_s2 : '0);
			none_s3   <= none_s2;
			conj_s3   <= conj_c;
			oor_s3    <= oor_s2;
		end
	end

	// stage 4: final add, range error zeroes the result
	logic [FLAT_W-1:0] sum_c;
	logic [FLAT_W-1:0] flat_s4;
	logic              conj_s4, oor_s4;

	assign sum_c = (none_s3 ? prod_s3[FLAT_W-1:0] : prod_s3[FLAT_W:1]) + addend_s3;

	always_ff @(posedge clk) begin
		if (ctrl.en[3]) begin
			flat_s4 <= oor_s3 ? '0 : sum_c;
			conj_s4 <= conj_s3 && !oor_s3;
			oor_s4  <= oor_s3;
		end
	end

	assign flat_index   = flat_s4;
	assign conjugate    = conj_s4;
	assign out_of_range = oor_s4;

endmodule

`default_nettype wire

// ===== hw/rtl/two_electron_integral_packed_index.sv =====
`default_nettype none

// two-electron integral packed index: every transfer on s_ carries the four
// orbital indices a, b, i, j of one integral <ab|ij>, and one transfer on m_
// returns its flat storage index in the array packed under the configured
// symmetry, a conjugation flag and a range error flag. the pipeline has four
// register stages, the last being the output register, and while m_tready is
// high a new item is taken every cycle; the stages follow the multiply chain
// (strides, dense product, then one shared multiplier for the final triangle
// in stage three). a stalled output only holds the stages that are full, so
// bubbles close up before the input is held back. the user must write
// configuration through cfg_ only when no item is in flight; the block does
// not enforce this. index 0 is the symmetry mode, index 1 the orbital count,
// which saturates at MAX_ORBITALS. there is no stored table and no start-up
// pass.
module two_electron_integral_packed_index
	import tei_pkg::*;
#(
	parameter int MAX_ORBITALS = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write channel
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CNT_W-1:0]      cfg_data,
	// input stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // orb_a, orb_b, orb_i, orb_j
	// result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata    // flat_index, conjugate, out_of_range, pad
);

	localparam int NW = ($clog2(MAX_ORBITALS + 1) > CNT_W) ? $clog2(MAX_ORBITALS + 1) : CNT_W;

	logic [MODE_W-1:0] mode;
	logic [NW-1:0]     n;
	ctrl_t             ctrl;
	logic [FLAT_W-1:0] flat_index;
	logic              conjugate;
	logic              out_of_range;

	// mode and orbital count registers
	tei_cfg #(
		.MAX_ORBITALS (MAX_ORBITALS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.n         (n)
	);

	// valid bits and per-stage load enables
	tei_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.ctrl     (ctrl)
	);

	// four-stage index arithmetic, last stage is the output register
	tei_datapath #(
		.MAX_ORBITALS (MAX_ORBITALS)
	) u_datapath (
		.clk          (clk),
		.ctrl         (ctrl),
		.mode         (mode),
		.n            (n),
		.orb_a        (s_tdata[ORB_W-1:0]),
		.orb_b        (s_tdata[2*ORB_W-1:ORB_W]),
		.orb_i        (s_tdata[3*ORB_W-1:2*ORB_W]),
		.orb_j        (s_tdata[4*ORB_W-1:3*ORB_W]),
		.flat_index   (flat_index),
		.conjugate    (conjugate),
		.out_of_range (out_of_range)
	);

	// pack the result, zero fill up to whole bytes
	assign m_tdata = {(OUT_DATA_W - FLAT_W - 2)'(0), out_of_range, conjugate, flat_index};

endmodule

`default_nettype wire

// ===== hw/rtl/tei_checker.sv =====
`default_nettype none

module tei_checker
	import tei_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata
);

	// a range error carries a zero index and no conjugation
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[FLAT_W+1] |-> m_tdata[FLAT_W:0] == '0)
		else $error("range error result not zeroed");

	// input is held back only behind a stalled result
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with output free");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// padding bits stay clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:FLAT_W+2] == '0)
		else $error("result padding not zero");

	// an empty pipeline fed nothing stays empty
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && s_tready && !s_tvalid ##1 !m_tvalid && s_tready && !s_tvalid
		##1 !m_tvalid && s_tready && !s_tvalid ##1 !m_tvalid && !s_tvalid |=> !m_tvalid)
		else $error("result without input");

endmodule

bind two_electron_integral_packed_index tei_checker u_tei_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
